// ===== hw/rtl/mbet_pkg.sv =====
// Shared types, constants and saturation helpers for the escape-time core.
package mbet_pkg;

  localparam int unsigned POINT_W = 48;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned OUT_W   = 16;

  localparam logic [63:0] ESCAPE_INT = 64'd250000;
  localparam logic [63:0] SAT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN    = 64'h8000_0000_0000_0000;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TEST = 4'b0010,
    S_MUL  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [1:0] {
    OP_XY = 2'd0,
    OP_XX = 2'd1,
    OP_YY = 2'd2
  } mul_op_t;

  // Clamp a 66-bit signed sum to the signed 64-bit range.
  function automatic logic [63:0] clamp66(input logic signed [65:0] v);
    logic [63:0] r;
    if (v[65:63] == 3'b000 || v[65:63] == 3'b111) begin
      r = v[63:0];
    end else if (v[65]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

  // Magnitude of a signed 64-bit word as an unsigned 64-bit word.
  function automatic logic [63:0] mag64(input logic [63:0] v);
    logic [63:0] r;
    r = v[63] ? (~v + 64'd1) : v;
    return r;
  endfunction

endpackage

// ===== hw/rtl/mandelbrot_escape_time_core.sv =====
// Escape-time iteration core: counts passes of z = z*z + c for one point.
//
// Usage: a point c = (point_real, point_imag) in signed fixed point with FRAC_BITS
// fraction bits is offered on in_valid/in_ready. The core takes one request at a
// time; in_ready is high only while no point is in work. The pass count comes out
// on iteration_count with out_valid/out_ready. The result sits in an output
// register, so the next point can be accepted while the previous count waits.
// The dwell limit max_iterations is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high and writes are meant for idle periods.
//
// Each pass runs three 64x64 products through one shared 32x32 multiplier,
// four partial products each, plus a test and an update step. A point that
// ends in the test step raises out_valid with its count, and the core is back
// in idle, ready for the next point, in the same cycle that out_valid rises.
// If the receiver stalls while a finished count is still waiting, the core holds
// its finished point in the test step until the output register frees up.
// Reset (rst, synchronous) empties the core and sets max_iterations to 65535.
module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS  = 44,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mbet_pkg::POINT_W-1:0] point_real,
  input  logic signed [mbet_pkg::POINT_W-1:0] point_imag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [mbet_pkg::OUT_W-1:0]   iteration_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [mbet_pkg::CFG_W-1:0]   cfg_data
);

  import mbet_pkg::*;

  // Squares shift by FRAC_BITS; the doubled cross product by one less.
  localparam int SH_SQ = FRAC_BITS;
  localparam int SH_XY = FRAC_BITS - 1;

  // Escape threshold 250000 in the working format, saturated when it cannot fit.
  localparam logic [63:0] ESC_LIMIT =
    (ESCAPE_INT > (SAT_MAX >> FRAC_BITS)) ? SAT_MAX : (ESCAPE_INT << FRAC_BITS);

  // Sequencer steps inside one product: load, four multiplies, drain, write back.
  localparam logic [2:0] CNT_LOAD = 3'd0;
  localparam logic [2:0] CNT_LAST = 3'd6;

  state_t                state;
  state_t                state_next;
  mul_op_t               op;
  logic [2:0]            cnt;
  logic [COUNT_BITS-1:0] max_iter;
  logic [COUNT_BITS-1:0] iter;

  // Point and iteration variables.
  logic [POINT_W-1:0]    cx;
  logic [POINT_W-1:0]    cy;
  logic [63:0]           x;
  logic [63:0]           y;
  logic [63:0]           x2;
  logic [63:0]           y2;
  logic [63:0]           tp;
  logic                  tp_neg;

  // Shared multiplier datapath.
  logic [63:0]           opa;
  logic [63:0]           opb;
  logic                  prod_neg;
  logic [63:0]           pp;
  logic [1:0]            pp_idx;
  logic [1:0]            mul_idx;
  logic [127:0]          acc;
  logic [127:0]          addend;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           sq_res;
  logic [63:0]           xy_res;

  logic [64:0]           mag_sum;
  logic                  keep_going;
  logic                  finish;
  logic signed [65:0]    nx_sum;
  logic signed [65:0]    ny_sum;
  logic signed [65:0]    cx_ext;
  logic signed [65:0]    cy_ext;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Escape and dwell test on the current squares.
  assign mag_sum    = {1'b0, x2} + {1'b0, y2};
  assign keep_going = (iter < max_iter) && (mag_sum < {1'b0, ESC_LIMIT});
  assign finish     = (state == S_TEST) && !keep_going && (!out_valid || out_ready);

  // Partial product select: low*low, low*high, high*low, high*high.
  assign mul_idx = 2'(cnt - 3'd1);
  always_comb begin
    mul_a = mul_idx[1] ? opa[63:32] : opa[31:0];
    mul_b = mul_idx[0] ? opb[63:32] : opb[31:0];
  end

  always_comb begin
    case (pp_idx) inside
      2'd0:       addend = {64'd0, pp};
      2'd1, 2'd2: addend = {32'd0, pp, 32'd0};
      default:    addend = {pp, 64'd0};
    endcase
  end

  // Truncating shift of the full product, saturated to the largest positive value.
  assign sq_res = (|acc[127:SH_SQ+63]) ? SAT_MAX : {1'b0, acc[SH_SQ+62:SH_SQ]};
  assign xy_res = (|acc[127:SH_XY+63]) ? SAT_MAX : {1'b0, acc[SH_XY+62:SH_XY]};

  // Next z from the stored squares and the signed cross product.
  assign cx_ext = {{(66-POINT_W){cx[POINT_W-1]}}, cx};
  assign cy_ext = {{(66-POINT_W){cy[POINT_W-1]}}, cy};
  assign nx_sum = $signed({2'b00, x2}) - $signed({2'b00, y2}) + cx_ext;
  assign ny_sum = tp_neg ? (cy_ext - $signed({2'b00, tp})) : (cy_ext + $signed({2'b00, tp}));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_TEST;
      end
      S_TEST: begin
        if (keep_going) begin
          state_next = S_MUL;
        end else if (finish) begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (cnt == CNT_LAST) begin
          if (op == OP_XY) begin
            state_next = S_UPD;
          end else if (op == OP_YY) begin
            state_next = S_TEST;
          end
        end
      end
      S_UPD: begin
        state_next = S_MUL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_XY;
      cnt       <= CNT_LOAD;
      out_valid <= 1'b0;
      max_iter  <= COUNT_BITS'(16'hFFFF);
      iter      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) max_iter <= COUNT_BITS'(cfg_data);

      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (state == S_IDLE && in_valid) begin
        iter <= '0;
      end else if (state == S_UPD) begin
        iter <= COUNT_BITS'(iter + 1'b1);
      end

      if (state == S_TEST && keep_going) begin
        op  <= OP_XY;
        cnt <= CNT_LOAD;
      end else if (state == S_UPD) begin
        op  <= OP_XX;
        cnt <= CNT_LOAD;
      end else if (state == S_MUL) begin
        if (cnt == CNT_LAST) begin
          cnt <= CNT_LOAD;
          if (op == OP_XX) op <= OP_YY;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (finish) iteration_count <= OUT_W'(iter);

    if (state == S_IDLE && in_valid) begin
      cx <= point_real;
      cy <= point_imag;
      x  <= '0;
      y  <= '0;
      x2 <= '0;
      y2 <= '0;
    end

    if (state == S_UPD) begin
      x <= clamp66(nx_sum);
      y <= clamp66(ny_sum);
    end

    if (state == S_MUL) begin
      if (cnt == CNT_LOAD) begin
        opa      <= (op == OP_YY) ? mag64(y) : mag64(x);
        opb      <= (op == OP_XX) ? mag64(x) : mag64(y);
        prod_neg <= x[63] ^ y[63];
        acc      <= '0;
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        pp     <= 64'(mul_a) * 64'(mul_b);
        pp_idx <= mul_idx;
      end
      if (cnt >= 3'd2 && cnt <= 3'd5) begin
        acc <= acc + addend;
      end
      if (cnt == CNT_LAST) begin
        case (op)
          OP_XY: begin
            tp     <= xy_res;
            tp_neg <= prod_neg;
          end
          OP_XX:   x2 <= sq_res;
          default: y2 <= sq_res;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_TEST |-> iter <= max_iter)
    else $error("pass count ran past the dwell limit");

  a_squares_positive: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> !x2[63] && !y2[63])
    else $error("stored square is negative");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_MUL |-> cnt == CNT_LOAD)
    else $error("multiplier step counter active outside a product");

  a_accept_to_test: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_TEST)
    else $error("accepted point did not start its test step");

  a_finish_output: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && state == S_IDLE)
    else $error("finished point did not reach the output register");
`endif

endmodule
